/* design/segx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg
// Widths and types shared by the segment intersection core.
// ----------------------------------------------------------------------------
package segx_pkg;

	localparam int COORD_BITS = 16;

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * CW;
	localparam int PRW  = PW + 1;
	localparam int EW   = 2 * DW;
	localparam int DETW = EW + 1;
	localparam int MW   = PRW + DW;
	localparam int NW   = MW + 1;
	localparam int RW   = NW + 1;
	localparam int QW   = CW + 1;
	localparam int SQW  = QW + 1;
	localparam int SHW  = $clog2(QW + 1);

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t ax_lo;
		coord_t ax_hi;
		coord_t ay_lo;
		coord_t ay_hi;
		coord_t bx_lo;
		coord_t bx_hi;
		coord_t by_lo;
		coord_t by_hi;
	} box_t;

	typedef struct packed {
		logic [RW-1:0]   rem_x;
		logic [RW-1:0]   rem_y;
		logic [DETW-1:0] dm;
		logic [QW-1:0]   q_x;
		logic [QW-1:0]   q_y;
		logic            neg_x;
		logic            neg_y;
		logic            miss;
		box_t            box;
	} div_t;

endpackage

/* design/segx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_in_if / segx_out_if
// Valid/ready channels for segment pairs and intersection results.
// ----------------------------------------------------------------------------
interface segx_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [segx_pkg::CW-1:0]    a_start_x;
	logic signed [segx_pkg::CW-1:0]    a_start_y;
	logic signed [segx_pkg::CW-1:0]    a_end_x;
	logic signed [segx_pkg::CW-1:0]    a_end_y;
	logic signed [segx_pkg::CW-1:0]    b_start_x;
	logic signed [segx_pkg::CW-1:0]    b_start_y;
	logic signed [segx_pkg::CW-1:0]    b_end_x;
	logic signed [segx_pkg::CW-1:0]    b_end_y;

	modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segx_out_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [segx_pkg::CW-1:0]    cross_x;
	logic signed [segx_pkg::CW-1:0]    cross_y;

	modport source (output valid, hit, cross_x, cross_y, input ready);
	modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

/* design/segx_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_div_stage
// One registered restoring division step for both crossing coordinates.
// ----------------------------------------------------------------------------
module segx_div_stage (
	input  logic                    clk,
	input  logic                    en,
	input  logic [segx_pkg::SHW-1:0] shift,
	input  segx_pkg::div_t          d_in,
	output segx_pkg::div_t          d_out
);
	import segx_pkg::*;

	div_t           nxt;
	logic [RW-1:0]  sub;
	div_t           d_sk;

	always_comb begin
		nxt = d_in;
		sub = RW'(d_in.dm) << shift;
		if (d_in.rem_x >= sub) begin
			nxt.rem_x = d_in.rem_x - sub;
			nxt.q_x   = {d_in.q_x[QW-2:0], 1'b1};
		end else begin
			nxt.q_x   = {d_in.q_x[QW-2:0], 1'b0};
		end
		if (d_in.rem_y >= sub) begin
			nxt.rem_y = d_in.rem_y - sub;
			nxt.q_y   = {d_in.q_y[QW-2:0], 1'b1};
		end else begin
			nxt.q_y   = {d_in.q_y[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_sk <= nxt;
		end
	end

	assign d_out = d_sk;

endmodule

/* design/segment_intersection_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_core
// Crossing point of two 2D segments in signed fixed point, with box test.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while the output is not stalled and
// returns one result per pair, in order: five stages of products and
// differences, then a 17-stage restoring divider (one quotient bit per
// stage, x and y side by side), then the bounding box check and output
// register. The whole pipeline holds while a result waits at the output.
// A miss, parallel lines or a quotient beyond the coordinate range give
// hit low with both coordinates zero.
module segment_intersection_core (
	input  logic        clk,
	input  logic        arst_n,
	segx_in_if.sink     segs,
	segx_out_if.source  result
);
	import segx_pkg::*;

	localparam int NST = QW + 6;
	localparam logic [QW-1:0] QLIM = {1'b1, {CW{1'b0}}};

	function automatic coord_t cmin(coord_t a, coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t cmax(coord_t a, coord_t b);
		return (a < b) ? b : a;
	endfunction

	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv         = !vld_q[NST-1] || result.ready;
	assign segs.ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], segs.valid};
		end
	end

	// stage 1: differences and point products
	logic signed [DW-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	logic signed [PW-1:0] pa_s1, pb_s1, pc_s1, pd_s1;
	box_t                 box_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx12_s1 <= DW'(segs.a_start_x) - DW'(segs.a_end_x);
			dy12_s1 <= DW'(segs.a_start_y) - DW'(segs.a_end_y);
			dx34_s1 <= DW'(segs.b_start_x) - DW'(segs.b_end_x);
			dy34_s1 <= DW'(segs.b_start_y) - DW'(segs.b_end_y);
			pa_s1   <= segs.a_start_x * segs.a_end_y;
			pb_s1   <= segs.a_start_y * segs.a_end_x;
			pc_s1   <= segs.b_start_x * segs.b_end_y;
			pd_s1   <= segs.b_start_y * segs.b_end_x;
			box_s1.ax_lo <= cmin(segs.a_start_x, segs.a_end_x);
			box_s1.ax_hi <= cmax(segs.a_start_x, segs.a_end_x);
			box_s1.ay_lo <= cmin(segs.a_start_y, segs.a_end_y);
			box_s1.ay_hi <= cmax(segs.a_start_y, segs.a_end_y);
			box_s1.bx_lo <= cmin(segs.b_start_x, segs.b_end_x);
			box_s1.bx_hi <= cmax(segs.b_start_x, segs.b_end_x);
			box_s1.by_lo <= cmin(segs.b_start_y, segs.b_end_y);
			box_s1.by_hi <= cmax(segs.b_start_y, segs.b_end_y);
		end
	end

	// stage 2: determinant products, pre and post terms
	logic signed [DW-1:0]  dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	logic signed [EW-1:0]  e1_s2, e2_s2;
	logic signed [PRW-1:0] pre_s2, post_s2;
	box_t                  box_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			dx34_s2 <= dx34_s1;
			dy34_s2 <= dy34_s1;
			e1_s2   <= dx12_s1 * dy34_s1;
			e2_s2   <= dy12_s1 * dx34_s1;
			pre_s2  <= PRW'(pa_s1) - PRW'(pb_s1);
			post_s2 <= PRW'(pc_s1) - PRW'(pd_s1);
			box_s2  <= box_s1;
		end
	end

	// stage 3: determinant, numerator products
	logic signed [DETW-1:0] d_s3;
	logic signed [MW-1:0]   m1_s3, m2_s3, m3_s3, m4_s3;
	box_t                   box_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3   <= DETW'(e1_s2) - DETW'(e2_s2);
			m1_s3  <= pre_s2 * dx34_s2;
			m2_s3  <= dx12_s2 * post_s2;
			m3_s3  <= pre_s2 * dy34_s2;
			m4_s3  <= dy12_s2 * post_s2;
			box_s3 <= box_s2;
		end
	end

	// stage 4: numerators
	logic signed [DETW-1:0] d_s4;
	logic signed [NW-1:0]   nx_s4, ny_s4;
	box_t                   box_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4   <= d_s3;
			nx_s4  <= NW'(m1_s3) - NW'(m2_s3);
			ny_s4  <= NW'(m3_s3) - NW'(m4_s3);
			box_s4 <= box_s3;
		end
	end

	// stage 5: magnitudes and signs
	logic [NW-1:0]   nmx_s5, nmy_s5;
	logic [DETW-1:0] dm_s5;
	logic            negx_s5, negy_s5, dz_s5;
	box_t            box_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			nmx_s5  <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
			nmy_s5  <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
			dm_s5   <= d_s4[DETW-1] ? DETW'(-d_s4) : DETW'(d_s4);
			negx_s5 <= nx_s4[NW-1] ^ d_s4[DETW-1];
			negy_s5 <= ny_s4[NW-1] ^ d_s4[DETW-1];
			dz_s5   <= (d_s4 == '0);
			box_s5  <= box_s4;
		end
	end

	// divider
	div_t          div_pipe [0:QW];
	logic [RW-1:0] lim;

	always_comb begin
		lim                = RW'(dm_s5) << QW;
		div_pipe[0].rem_x  = RW'(nmx_s5);
		div_pipe[0].rem_y  = RW'(nmy_s5);
		div_pipe[0].dm     = dm_s5;
		div_pipe[0].q_x    = '0;
		div_pipe[0].q_y    = '0;
		div_pipe[0].neg_x  = negx_s5;
		div_pipe[0].neg_y  = negy_s5;
		div_pipe[0].miss   = dz_s5 || (RW'(nmx_s5) >= lim) || (RW'(nmy_s5) >= lim);
		div_pipe[0].box    = box_s5;
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		segx_div_stage u_stage (
			.clk   (clk),
			.en    (adv),
			.shift (SHW'(QW - 1 - j)),
			.d_in  (div_pipe[j]),
			.d_out (div_pipe[j+1])
		);
	end

	// output stage: sign, range and box test
	div_t                  dq;
	logic signed [SQW-1:0] sqx, sqy;
	logic                  hit_c;
	logic                  hit_s6;
	coord_t                cx_s6, cy_s6;

	always_comb begin
		dq    = div_pipe[QW];
		sqx   = dq.neg_x ? -$signed({1'b0, dq.q_x}) : $signed({1'b0, dq.q_x});
		sqy   = dq.neg_y ? -$signed({1'b0, dq.q_y}) : $signed({1'b0, dq.q_y});
		hit_c = !dq.miss && (dq.q_x <= QLIM) && (dq.q_y <= QLIM)
			&& (sqx >= SQW'(dq.box.ax_lo)) && (sqx <= SQW'(dq.box.ax_hi))
			&& (sqx >= SQW'(dq.box.bx_lo)) && (sqx <= SQW'(dq.box.bx_hi))
			&& (sqy >= SQW'(dq.box.ay_lo)) && (sqy <= SQW'(dq.box.ay_hi))
			&& (sqy >= SQW'(dq.box.by_lo)) && (sqy <= SQW'(dq.box.by_hi));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s6 <= hit_c;
			cx_s6  <= hit_c ? sqx[CW-1:0] : '0;
			cy_s6  <= hit_c ? sqy[CW-1:0] : '0;
		end
	end

	assign result.valid   = vld_q[NST-1];
	assign result.hit     = hit_s6;
	assign result.cross_x = cx_s6;
	assign result.cross_y = cy_s6;

endmodule

/* dv/segx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_checker
// Watches the segment pair and result channels of the intersection core,
// predicts each crossing with a 64-bit integer model and compares in order.
// ----------------------------------------------------------------------------
module segx_checker (
	input  logic clk,
	input  logic arst_n,
	segx_in_if   segs,
	segx_out_if  result,
	output int   fails,
	output int   pending
);
	import segx_pkg::*;

	typedef struct packed {
		logic   hit;
		coord_t cx;
		coord_t cy;
	} crossing_t;

	crossing_t crossings_due[$];
	int        reported;

	function automatic logic trunc_quot(input longint n, input longint d, output longint q);
		logic   ns;
		logic   ds;
		longint nm;
		longint dm;
		longint qm;
		ns = n < 0;
		ds = d < 0;
		nm = ns ? -n : n;
		dm = ds ? -d : d;
		qm = longint'(unsigned'(nm) / unsigned'(dm));
		if (unsigned'(qm) > (64'd1 << CW))
			return 1'b0;
		q = (ns != ds) ? -qm : qm;
		return 1'b1;
	endfunction

	function automatic logic spans(input longint v, input longint a, input longint b);
		return (v >= ((a < b) ? a : b)) && (v <= ((a < b) ? b : a));
	endfunction

	function automatic crossing_t predict_crossing(input longint x1, input longint y1,
		input longint x2, input longint y2, input longint x3, input longint y3,
		input longint x4, input longint y4);
		crossing_t r;
		longint    det;
		longint    pre;
		longint    post;
		longint    qx;
		longint    qy;
		r = '0;
		det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
		if (det != 0) begin
			pre = x1 * y2 - y1 * x2;
			post = x3 * y4 - y3 * x4;
			if (trunc_quot(pre * (x3 - x4) - (x1 - x2) * post, det, qx) &&
				trunc_quot(pre * (y3 - y4) - (y1 - y2) * post, det, qy)) begin
				r.hit = spans(qx, x1, x2) && spans(qx, x3, x4) &&
					spans(qy, y1, y2) && spans(qy, y3, y4);
				if (r.hit) begin
					r.cx = coord_t'(qx);
					r.cy = coord_t'(qy);
				end
			end
		end
		return r;
	endfunction

	assign pending = crossings_due.size();

	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			if (segs.valid && segs.ready)
				crossings_due.push_back(predict_crossing(segs.a_start_x, segs.a_start_y,
					segs.a_end_x, segs.a_end_y, segs.b_start_x, segs.b_start_y,
					segs.b_end_x, segs.b_end_y));
			if (result.valid && result.ready) begin
				if (crossings_due.size() == 0) begin
					fails <= fails + 1;
					if (reported < 10)
						$display("unexpected result beat hit=%0b x=%0d y=%0d",
							result.hit, result.cross_x, result.cross_y);
					reported++;
				end else begin
					want = crossings_due.pop_front();
					if (want.hit !== result.hit || want.cx !== result.cross_x ||
						want.cy !== result.cross_y) begin
						fails <= fails + 1;
						if (reported < 10)
							$display("mismatch: exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
								want.hit, want.cx, want.cy, result.hit,
								result.cross_x, result.cross_y);
						reported++;
					end
				end
			end
		end
	end

	initial begin
		fails = 0;
		reported = 0;
	end
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Segment intersection core test: directed pairs, crossing pairs built from
// random lines and raw random pairs, with bursty input and stalled output.
// ----------------------------------------------------------------------------
module tb;
	import segx_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles;
	int   hold_off;
	logic long_stall_done;

	segx_in_if  segs ();
	segx_out_if result ();

	segment_intersection_core u_top (.clk(clk), .arst_n(arst_n), .segs(segs), .result(result));
	segx_checker u_chk (.clk(clk), .arst_n(arst_n), .segs(segs), .result(result),
		.fails(fails), .pending(pending));

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stall pattern, one long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else if (!long_stall_done && cycles == 300) begin
			hold_off <= 120;
			long_stall_done <= 1'b1;
			result.ready <= 1'b0;
		end else if ((cycles / 500) % 3 == 0)
			result.ready <= 1'b1;
		else
			result.ready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send_pair(input coord_t v[8]);
		segs.valid <= 1'b1;
		segs.a_start_x <= v[0];
		segs.a_start_y <= v[1];
		segs.a_end_x <= v[2];
		segs.a_end_y <= v[3];
		segs.b_start_x <= v[4];
		segs.b_start_y <= v[5];
		segs.b_end_x <= v[6];
		segs.b_end_y <= v[7];
		do @(posedge clk); while (!segs.ready);
	endtask

	task automatic pause_sender();
		int g;
		g = $urandom_range(1, 6);
		segs.valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	function automatic coord_t rnd_coord(input int span);
		if (span == 0)
			return coord_t'($urandom);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	coord_t v[8];
	int     burst;
	int     span;

	initial begin
		clk = 0;
		arst_n = 0;
		cycles = 0;
		hold_off = 0;
		long_stall_done = 0;
		result.ready = 0;
		segs.valid = 0;
		{segs.a_start_x, segs.a_start_y, segs.a_end_x, segs.a_end_y} = '0;
		{segs.b_start_x, segs.b_start_y, segs.b_end_x, segs.b_end_y} = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// crossing at origin, parallel, collinear, degenerate, extremes
		v = '{-16, -16, 16, 16, -16, 16, 16, -16}; send_pair(v);
		v = '{0, 0, 160, 0, 0, 16, 160, 16}; send_pair(v);
		v = '{0, 0, 160, 160, 16, 16, 320, 320}; send_pair(v);
		v = '{5, 5, 5, 5, 0, 0, 16, 16}; send_pair(v);
		v = '{0, 0, 16, 16, 32, 0, 64, -32}; send_pair(v);
		v = '{0, 0, 32, 0, 32, -16, 32, 16}; send_pair(v);
		v = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}; send_pair(v);
		v = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767}; send_pair(v);
		v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_pair(v);
		v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}; send_pair(v);
		v = '{-32768, -32768, 32767, -32767, -32768, 32767, 32767, -32768}; send_pair(v);
		v = '{0, 0, 1, 1000, 0, 1, 1, -1000}; send_pair(v);
		v = '{-1, -1, 1, 1, -1, 1, 1, -1}; send_pair(v);
		v = '{0, 0, 3, 7, 0, 7, 3, 0}; send_pair(v);
		v = '{0, 0, 16, 0, 0, 1, 16, 2}; send_pair(v);
		v = '{-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845}; send_pair(v);

		for (int n = 0; n < 1850;) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++, n++) begin
				span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(3, 15));
				if (span > 32767)
					span = 32767;
				if ($urandom_range(0, 4) != 0) begin
					// two segments through a shared point
					coord_t px, py;
					px = rnd_coord(span / 2);
					py = rnd_coord(span / 2);
					for (int i = 0; i < 8; i += 4) begin
						v[i] = px - rnd_coord(span / 2);
						v[i + 1] = py - rnd_coord(span / 2);
						v[i + 2] = coord_t'(2 * px - v[i]);
						v[i + 3] = coord_t'(2 * py - v[i + 1]);
					end
				end else
					foreach (v[i]) v[i] = rnd_coord(span);
				send_pair(v);
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender();
		end
		segs.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
